// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by rotation_matrix_to_euler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequence checked a fixed number of cycles later
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

// ----- design/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg
// Types, constants and the arctangent table of the Euler angle extractor.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int CORDIC_XW         = 36;
    localparam int CORDIC_ZW         = 29;
    localparam int SQRT_STEPS        = 15;
    localparam int SQRT_W            = 30;
    localparam int RAD_W             = 29;

    localparam logic signed [CORDIC_ZW-1:0] PI_Q24 = 29'sd52707179;
    localparam logic signed [14:0] HALF_PI_Q13 = 15'sd12868;

    localparam logic signed [CORDIC_ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
        29'sd13176795, 29'sd7778716, 29'sd4110060, 29'sd2086331,
        29'sd1047214,  29'sd524117,  29'sd262123,  29'sd131069,
        29'sd65536,    29'sd32768,   29'sd16384,   29'sd8192,
        29'sd4096,     29'sd2048,    29'sd1024,    29'sd512,
        29'sd256,      29'sd128,     29'sd64,      29'sd32,
        29'sd16,       29'sd8,       29'sd4,       29'sd2
    };

    typedef logic [1:0] lock_t;
    localparam lock_t LOCK_NONE = 2'd0;
    localparam lock_t LOCK_POS  = 2'd1;
    localparam lock_t LOCK_NEG  = 2'd2;

    // operands carried alongside the square root
    typedef struct packed {
        logic signed [15:0] pitch_y;
        logic signed [15:0] pitch_x;
        logic signed [15:0] roll_y;
        logic signed [15:0] roll_x;
        logic signed [16:0] yaw_y;
        lock_t              lock;
    } ops_t;

endpackage

// ----- design/rme_sqrt.sv -----
// ----------------------------------------------------------------------------
// rme_sqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rme_sqrt
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [rme_pkg::RAD_W-1:0]        rad,
    input  rme_pkg::ops_t                    ops_in,
    output logic                             out_valid,
    output logic [14:0]                      root,
    output rme_pkg::ops_t                    ops_out
);
    localparam int N  = rme_pkg::SQRT_STEPS;
    localparam int SW = rme_pkg::SQRT_W;

    logic [SW-1:0]  v_reg   [N];
    logic [SW-1:0]  r_reg   [N];
    logic           vld_reg [N];
    rme_pkg::ops_t  ops_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - 1 - k));
        logic [SW-1:0]  v_cur, r_cur, trial;
        logic           vld_cur;
        rme_pkg::ops_t  ops_cur;

        if (k == 0) begin : g_first
            always_comb
            begin
                v_cur   = SW'(rad);
                r_cur   = '0;
                vld_cur = in_valid;
                ops_cur = ops_in;
            end
        end else begin : g_next
            always_comb
            begin
                v_cur   = v_reg[k-1];
                r_cur   = r_reg[k-1];
                vld_cur = vld_reg[k-1];
                ops_cur = ops_reg[k-1];
            end
        end

        assign trial = r_cur + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            ops_reg[k] <= ops_cur;
            if (v_cur >= trial)
            begin
                v_reg[k] <= v_cur - trial;
                r_reg[k] <= (r_cur >> 1) + BIT;
            end
            else
            begin
                v_reg[k] <= v_cur;
                r_reg[k] <= r_cur >> 1;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = r_reg[N-1][14:0];
    assign ops_out   = ops_reg[N-1];

endmodule

// ----- design/rme_cordic.sv -----
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in Q3.13 radians.
// ----------------------------------------------------------------------------
module rme_cordic
#(
    parameter int STAGES = rme_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [16:0]  y_in,
    input  logic signed [16:0]  x_in,
    input  rme_pkg::lock_t      tag_in,
    output logic                out_valid,
    output logic signed [15:0]  angle,
    output rme_pkg::lock_t      tag_out
);
    localparam int XW = rme_pkg::CORDIC_XW;
    localparam int ZW = rme_pkg::CORDIC_ZW;
    localparam int NS = (STAGES > rme_pkg::TABLE_LEN) ? rme_pkg::TABLE_LEN : STAGES;
    localparam logic signed [ZW:0] HALF_LSB = (ZW+1)'(1024);

    logic signed [XW-1:0] x_reg    [NS+1];
    logic signed [XW-1:0] y_reg    [NS+1];
    logic signed [ZW-1:0] z_reg    [NS+1];
    logic                 zero_reg [NS+1];
    logic                 vld_reg  [NS+1];
    rme_pkg::lock_t       tag_reg  [NS+1];

    logic signed [XW-1:0] x_sc, y_sc;

    assign x_sc = XW'(x_in) <<< 16;
    assign y_sc = XW'(y_in) <<< 16;

    // pre-rotation into the right half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0]  <= tag_in;
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            x_reg[0] <= -x_sc;
            y_reg[0] <= -y_sc;
            z_reg[0] <= (y_in >= 0) ? rme_pkg::PI_Q24 : -rme_pkg::PI_Q24;
        end
        else
        begin
            x_reg[0] <= x_sc;
            y_reg[0] <= y_sc;
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic signed [XW-1:0] xs, ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            tag_reg[i+1]  <= tag_reg[i];
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + rme_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - rme_pkg::ATAN_TAB[i];
            end
        end
    end

    // round Q.24 to Q3.13, halves away from zero
    logic signed [ZW:0] z_ext, z_rnd;

    always_comb
    begin
        z_ext = (ZW+1)'(z_reg[NS]);
        if (z_ext >= 0)
            z_rnd = (z_ext + HALF_LSB) >>> 11;
        else
            z_rnd = -((-z_ext + HALF_LSB) >>> 11);
    end

    logic                vld_out_reg;
    logic signed [15:0]  angle_reg;
    rme_pkg::lock_t      tag_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else
            vld_out_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        tag_out_reg <= tag_reg[NS];
        angle_reg   <= zero_reg[NS] ? '0 : z_rnd[15:0];
    end

    assign out_valid = vld_out_reg;
    assign angle     = angle_reg;
    assign tag_out   = tag_out_reg;

endmodule

// ----- design/rotation_matrix_to_euler.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// Rotation matrix Q2.14 to XYZ Euler angles Q3.13 rad (yaw Q2.13), gimbal lock
// ----------------------------------------------------------------------------
// Fully pipelined: a matrix is taken in every cycle (busy stays low) and
// its angles appear on the done strobe once the start transfer has passed
// three input stages, the 15-stage square root of 1 - m31^2 and the
// CORDIC pipeline with its pre-rotation and rounding stages, plus the
// output register. The receiver cannot stall; each result is shown for
// one cycle only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_euler
#(
    parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [14:0]         cfg_data,
    input  logic signed [15:0]  m11,
    input  logic signed [15:0]  m12,
    input  logic signed [15:0]  m13,
    input  logic signed [15:0]  m21,
    input  logic signed [15:0]  m31,
    input  logic signed [15:0]  m32,
    input  logic signed [15:0]  m33,
    output logic                done,
    output logic signed [15:0]  roll_angle,
    output logic signed [15:0]  pitch_angle,
    output logic signed [14:0]  yaw_angle,
    output rme_pkg::lock_t      lock_case
);
    localparam int LATENCY = CORDIC_STAGES + rme_pkg::SQRT_STEPS + 6;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [14:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 15'd16;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    // stage 0: capture the matrix
    logic               s0_vld_reg;
    logic signed [15:0] s0_m11_reg, s0_m12_reg, s0_m13_reg, s0_m21_reg;
    logic signed [15:0] s0_m31_reg, s0_m32_reg, s0_m33_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else
            s0_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_m11_reg <= m11;
        s0_m12_reg <= m12;
        s0_m13_reg <= m13;
        s0_m21_reg <= m21;
        s0_m31_reg <= m31;
        s0_m32_reg <= m32;
        s0_m33_reg <= m33;
    end

    // stage 1: lock test, operand select, square of m31
    logic signed [17:0] dp, dm;
    logic [17:0]        dp_abs, dm_abs;
    rme_pkg::lock_t     lock_next;

    always_comb
    begin
        dp     = 18'sd16384 - 18'(s0_m31_reg);
        dm     = -18'sd16384 - 18'(s0_m31_reg);
        dp_abs = (dp < 0) ? 18'(-dp) : 18'(dp);
        dm_abs = (dm < 0) ? 18'(-dm) : 18'(dm);
        if (dp_abs <= 18'(thr_reg))
            lock_next = rme_pkg::LOCK_POS;
        else if (dm_abs <= 18'(thr_reg))
            lock_next = rme_pkg::LOCK_NEG;
        else
            lock_next = rme_pkg::LOCK_NONE;
    end

    logic               s1_vld_reg;
    rme_pkg::ops_t      s1_ops_reg;
    logic [30:0]        s1_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_sq_reg          <= 31'(32'(s0_m31_reg) * 32'(s0_m31_reg));
        s1_ops_reg.lock    <= lock_next;
        s1_ops_reg.roll_y  <= s0_m21_reg;
        s1_ops_reg.roll_x  <= s0_m11_reg;
        s1_ops_reg.yaw_y   <= -17'(s0_m31_reg);
        if (lock_next != rme_pkg::LOCK_NONE)
        begin
            s1_ops_reg.pitch_y <= s0_m12_reg;
            s1_ops_reg.pitch_x <= s0_m13_reg;
        end
        else
        begin
            s1_ops_reg.pitch_y <= s0_m32_reg;
            s1_ops_reg.pitch_x <= s0_m33_reg;
        end
    end

    // stage 2: radicand 1 - m31^2, clamped at zero
    localparam logic [30:0] ONE_Q28 = 31'd268435456;

    logic                        s2_vld_reg;
    rme_pkg::ops_t               s2_ops_reg;
    logic [rme_pkg::RAD_W-1:0]   s2_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_ops_reg <= s1_ops_reg;
        if (s1_sq_reg >= ONE_Q28)
            s2_rad_reg <= '0;
        else
            s2_rad_reg <= rme_pkg::RAD_W'(ONE_Q28 - s1_sq_reg);
    end

    logic           sq_vld;
    logic [14:0]    sq_root;
    rme_pkg::ops_t  sq_ops;

    rme_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .rad       (s2_rad_reg),
        .ops_in    (s2_ops_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .ops_out   (sq_ops)
    );

    logic               yaw_vld;
    logic signed [15:0] yaw_raw, pitch_raw, roll_raw;
    rme_pkg::lock_t     lock_d;

    rme_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .y_in      (sq_ops.yaw_y),
        .x_in      ($signed({2'b00, sq_root})),
        .tag_in    (sq_ops.lock),
        .out_valid (yaw_vld),
        .angle     (yaw_raw),
        .tag_out   (lock_d)
    );

    rme_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .y_in      (17'(sq_ops.pitch_y)),
        .x_in      (17'(sq_ops.pitch_x)),
        .tag_in    (sq_ops.lock),
        .out_valid (),
        .angle     (pitch_raw),
        .tag_out   ()
    );

    rme_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .y_in      (17'(sq_ops.roll_y)),
        .x_in      (17'(sq_ops.roll_x)),
        .tag_in    (sq_ops.lock),
        .out_valid (),
        .angle     (roll_raw),
        .tag_out   ()
    );

    // output register: override roll and yaw under gimbal lock
    logic               done_reg;
    logic signed [15:0] roll_reg, pitch_reg;
    logic signed [14:0] yaw_reg;
    rme_pkg::lock_t     lock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= yaw_vld;
    end

    always_ff @(posedge clk)
    begin
        lock_reg  <= lock_d;
        pitch_reg <= pitch_raw;
        unique case (lock_d)
            rme_pkg::LOCK_POS:
            begin
                roll_reg <= '0;
                yaw_reg  <= -rme_pkg::HALF_PI_Q13;
            end
            rme_pkg::LOCK_NEG:
            begin
                roll_reg <= '0;
                yaw_reg  <= rme_pkg::HALF_PI_Q13;
            end
            default:
            begin
                roll_reg <= roll_raw;
                yaw_reg  <= yaw_raw[14:0];
            end
        endcase
    end

    assign done        = done_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign lock_case   = lock_reg;

    `ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LATENCY, done)
    `ASSERT_IMPLY(a_lock_roll, clk, rst_n, done && (lock_case != rme_pkg::LOCK_NONE), roll_angle == '0)
    `ASSERT_IMPLY(a_lock_pos_yaw, clk, rst_n, done && (lock_case == rme_pkg::LOCK_POS), yaw_angle == -rme_pkg::HALF_PI_Q13)
    `ASSERT_IMPLY(a_lock_code, clk, rst_n, done, lock_case != 2'd3)

endmodule
